// ----- hdl/x86enc_pkg.sv -----
// ----------------------------------------------------------------------------
// x86enc_pkg: shared types and constants of the x86-64 instruction encoder
// Holds the request and result payload types, the instruction kind codes and
// the entry type that travels from the decoder to the byte serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

package x86enc_pkg;

    // Longest instruction (mov reg,imm64) is ten bytes.
    localparam int MaxBytes = 10;
    localparam int LenW     = $clog2(MaxBytes + 1);

    // Depth of the queue between the decoder and the serialiser.
    localparam int QDepth   = 2;
    localparam int QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW    = $clog2(QDepth + 1);

    typedef enum logic [3:0] {
        OP_STORE    = 4'd0,
        OP_LOAD     = 4'd1,
        OP_MOV_IMM  = 4'd2,
        OP_ALU      = 4'd3,
        OP_IMUL     = 4'd4,
        OP_MOV_RR   = 4'd5,
        OP_CMP      = 4'd6,
        OP_SETCC    = 4'd7,
        OP_ZERO_EXT = 4'd8
    } t_op;

    typedef struct packed {
        logic [3:0]         op;
        logic [7:0]         alu_opcode;
        logic [3:0]         dst_reg;
        logic [3:0]         src_reg;
        logic [3:0]         cond_code;
        logic signed [31:0] displacement;
        logic [63:0]        immediate;
    } t_req;

    typedef struct packed {
        logic [7:0]  code_byte;
        logic        last_byte;
        logic [31:0] byte_position;
    } t_res;

    // One decoded instruction: bytes in emission order, first byte in [7:0].
    typedef struct packed {
        logic [8*MaxBytes-1:0] bytes;
        logic [LenW-1:0]       len;
    } t_entry;

    // Queue to serialiser hand-over.
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qout;

endpackage

`default_nettype wire

// ----- hdl/x86enc_front.sv -----
// ----------------------------------------------------------------------------
// x86enc_front: instruction decoder
// Classifies one request and lays out its complete machine code as a byte
// string with a length; unused kinds are flagged as producing nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module x86enc_front
    import x86enc_pkg::*;
(
    input  wire t_req   i_req,
    output logic        o_valid,
    output t_entry      o_entry
);

    // REX.W prefix with the R and B extension bits.
    function automatic logic [7:0] rex_w(input logic [3:0] reg_f, input logic [3:0] rm_f);
        rex_w = {5'b01001, reg_f[3], 1'b0, rm_f[3]};
    endfunction

    function automatic logic [7:0] modrm(input logic [1:0] md, input logic [3:0] reg_f,
                                         input logic [3:0] rm_f);
        modrm = {md, reg_f[2:0], rm_f[2:0]};
    endfunction

    logic [3:0] dst;
    logic [3:0] src;

    assign dst = i_req.dst_reg;
    assign src = i_req.src_reg;

    always_comb begin
        o_valid       = 1'b1;
        o_entry.bytes = '0;
        o_entry.len   = '0;
        case (i_req.op)
            OP_STORE: begin
                o_entry.bytes[7:0]   = rex_w(src, 4'd0);
                o_entry.bytes[15:8]  = 8'h89;
                o_entry.bytes[23:16] = modrm(2'b10, src, 4'd5);
                o_entry.bytes[55:24] = i_req.displacement;
                o_entry.len          = LenW'(7);
            end
            OP_LOAD: begin
                o_entry.bytes[7:0]   = rex_w(dst, 4'd0);
                o_entry.bytes[15:8]  = 8'h8B;
                o_entry.bytes[23:16] = modrm(2'b10, dst, 4'd5);
                o_entry.bytes[55:24] = i_req.displacement;
                o_entry.len          = LenW'(7);
            end
            OP_MOV_IMM: begin
                o_entry.bytes[7:0]   = rex_w(4'd0, dst);
                o_entry.bytes[15:8]  = {5'b10111, dst[2:0]};
                o_entry.bytes[79:16] = i_req.immediate;
                o_entry.len          = LenW'(10);
            end
            OP_ALU: begin
                o_entry.bytes[7:0]   = rex_w(src, dst);
                o_entry.bytes[15:8]  = i_req.alu_opcode;
                o_entry.bytes[23:16] = modrm(2'b11, src, dst);
                o_entry.len          = LenW'(3);
            end
            OP_IMUL: begin
                o_entry.bytes[7:0]   = rex_w(dst, src);
                o_entry.bytes[15:8]  = 8'h0F;
                o_entry.bytes[23:16] = 8'hAF;
                o_entry.bytes[31:24] = modrm(2'b11, dst, src);
                o_entry.len          = LenW'(4);
            end
            OP_MOV_RR: begin
                o_entry.bytes[7:0]   = rex_w(src, dst);
                o_entry.bytes[15:8]  = 8'h89;
                o_entry.bytes[23:16] = modrm(2'b11, src, dst);
                o_entry.len          = LenW'(3);
            end
            OP_CMP: begin
                o_entry.bytes[7:0]   = rex_w(src, dst);
                o_entry.bytes[15:8]  = 8'h39;
                o_entry.bytes[23:16] = modrm(2'b11, src, dst);
                o_entry.len          = LenW'(3);
            end
            OP_SETCC: begin
                // Registers 4 to 7 need a bare REX so that the low byte of
                // rsp, rbp, rsi and rdi is selected rather than ah to bh.
                if (dst[3] || dst[2]) begin
                    o_entry.bytes[7:0]   = {7'b0100000, dst[3]};
                    o_entry.bytes[15:8]  = 8'h0F;
                    o_entry.bytes[23:16] = {4'h9, i_req.cond_code};
                    o_entry.bytes[31:24] = modrm(2'b11, 4'd0, dst);
                    o_entry.len          = LenW'(4);
                end else begin
                    o_entry.bytes[7:0]   = 8'h0F;
                    o_entry.bytes[15:8]  = {4'h9, i_req.cond_code};
                    o_entry.bytes[23:16] = modrm(2'b11, 4'd0, dst);
                    o_entry.len          = LenW'(3);
                end
            end
            OP_ZERO_EXT: begin
                o_entry.bytes[7:0]   = rex_w(dst, src);
                o_entry.bytes[15:8]  = 8'h0F;
                o_entry.bytes[23:16] = 8'hB6;
                o_entry.bytes[31:24] = modrm(2'b11, dst, src);
                o_entry.len          = LenW'(4);
            end
            default: begin
                o_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/x86enc_queue.sv -----
// ----------------------------------------------------------------------------
// x86enc_queue: decoded instruction queue
// A short first-in first-out store of decoded instructions between the
// decoder and the serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

module x86enc_queue
    import x86enc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_wr,
    input  wire t_entry i_entry,
    input  wire         i_rd,
    output logic        o_full,
    output t_qout       o_q
);

    t_entry           r_mem [QDepth];
    logic [QPtrW-1:0] r_wptr;
    logic [QPtrW-1:0] r_rptr;
    logic [QCntW-1:0] r_cnt;

    function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
        ptr_inc = (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_rd) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full     = (r_cnt == QCntW'(QDepth));
    assign o_q.valid  = (r_cnt != '0);
    assign o_q.entry  = r_mem[r_rptr];

endmodule

`default_nettype wire

// ----- hdl/x86enc_back.sv -----
// ----------------------------------------------------------------------------
// x86enc_back: byte serialiser
// Shifts one decoded instruction out a byte at a time into the result
// register, marks the final byte and keeps the running byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module x86enc_back
    import x86enc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire t_qout i_q,
    output logic       o_q_rd,
    input  wire        i_pop,
    output logic       o_empty,
    output t_res       o_res
);

    logic                  r_busy,      n_busy;
    logic [8*MaxBytes-1:0] r_bytes,     n_bytes;
    logic [LenW-1:0]       r_left,      n_left;
    logic [31:0]           r_count,     n_count;
    logic                  r_out_valid, n_out_valid;
    t_res                  r_out,       n_out;

    logic slot_free;
    logic emit;
    logic is_last;
    logic load;

    assign slot_free = !r_out_valid || i_pop;
    assign emit      = r_busy && slot_free;
    assign is_last   = (r_left == LenW'(1));
    assign load      = i_q.valid && (!r_busy || (emit && is_last));
    assign o_q_rd    = load;

    always_comb begin
        n_busy      = r_busy;
        n_bytes     = r_bytes;
        n_left      = r_left;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out_valid         = 1'b1;
            n_out.code_byte     = r_bytes[7:0];
            n_out.last_byte     = is_last;
            n_out.byte_position = r_count;
            n_count             = r_count + 32'd1;
            n_bytes             = r_bytes >> 8;
            n_left              = r_left - 1'b1;
            if (is_last) begin
                n_busy = 1'b0;
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_busy  = 1'b1;
            n_bytes = i_q.entry.bytes;
            n_left  = i_q.entry.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_bytes <= n_bytes;
        r_left  <= n_left;
        r_out   <= n_out;
    end

    assign o_empty = !r_out_valid;
    assign o_res   = r_out;

`ifndef SYNTHESIS
    a_busy_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0 && r_left <= LenW'(MaxBytes)))
        else $error("serialiser busy with an impossible byte count");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_count == $past(r_count) + 32'd1))
        else $error("byte count did not advance with an emitted byte");

    a_position_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_out.byte_position + 32'd1 == r_count))
        else $error("result position disagrees with the running count");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_busy) |-> (emit && is_last))
        else $error("new instruction loaded over one still being sent");
`endif

endmodule

`default_nettype wire

// ----- hdl/x86_64_instruction_byte_encoder_top.sv -----
// An accepted request goes into the queue, then the serialiser, then the result register on o_res.
// Throughput: one machine code byte per cycle while pop is held high; instructions are 3 to 10 bytes.
// The figure is set by the single byte-wide serialiser that drives the result register.
// Requests of an unused kind are accepted and produce no bytes.
// Reset is synchronous and active low; it empties the queue, the serialiser and the result
// register and clears the running byte count to zero.
// ----------------------------------------------------------------------------
// x86_64_instruction_byte_encoder_top: x86-64 instruction byte encoder
// Turns instruction requests into their machine code, one byte per result,
// with the final byte marked and a running byte position.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_64_instruction_byte_encoder_top
    import x86enc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    // Request side, queue style: a request is taken when push is high and full is low.
    input  wire        push,
    output logic       full,
    input  wire t_req  i_req,
    // Result side, queue style: the oldest byte is shown while empty is low.
    output logic       empty,
    input  wire        pop,
    output t_res       o_res
);

    // The decoder is purely combinational and sits in front of the queue, so
    // the queue register is the boundary between the front and back halves.
    // The queue lets the decoder take a new request while the serialiser is
    // still sending the bytes of earlier ones.

    logic   dec_valid;
    t_entry dec_entry;
    logic   q_full;
    logic   q_wr;
    logic   q_rd;
    t_qout  q_out;

    x86enc_front u_front (
        .i_req   (i_req),
        .o_valid (dec_valid),
        .o_entry (dec_entry)
    );

    // A request of an unused kind is accepted but never enters the queue,
    // so it leaves the byte count untouched.
    assign full = q_full;
    assign q_wr = push && !q_full && dec_valid;

    x86enc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_entry (dec_entry),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_q     (q_out)
    );

    // The serialiser pulls the next instruction in the same cycle as it sends
    // the final byte of the current one, so bytes flow without gaps.
    x86enc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_out),
        .o_q_rd  (q_rd),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ----- bench/x86_64_instruction_byte_encoder_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_64_instruction_byte_encoder_top_test: self-checking bench for the encoder
// A directed table of requests is sent first, then a long random run. Each byte
// that leaves the block is compared with hand-written or in-bench encoded bytes
// with the running byte position. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module x86_64_instruction_byte_encoder_top_test;
    import x86enc_pkg::*;

    // Kinds beyond the last defined one; the block must ignore them.
    localparam logic [3:0] OpUnusedLo = 4'd9;
    localparam logic [3:0] OpUnusedHi = 4'd15;

    // Encoding fragments of the supported instructions.
    localparam logic [7:0] RexW         = 8'h48;
    localparam logic [7:0] RexR         = 8'h04;
    localparam logic [7:0] RexB         = 8'h01;
    localparam logic [7:0] RexBare      = 8'h40;
    localparam logic [7:0] OpcMovStore  = 8'h89;
    localparam logic [7:0] OpcMovLoad   = 8'h8B;
    localparam logic [7:0] OpcMovImm    = 8'hB8;
    localparam logic [7:0] OpcEscape    = 8'h0F;
    localparam logic [7:0] OpcImul      = 8'hAF;
    localparam logic [7:0] OpcCmp       = 8'h39;
    localparam logic [7:0] OpcSetccBase = 8'h90;
    localparam logic [7:0] OpcMovzx     = 8'hB6;
    localparam logic [7:0] ModDisp32    = 8'h80;
    localparam logic [7:0] ModReg       = 8'hC0;
    localparam logic [3:0] RegRbp       = 4'd5;

    localparam int RandomItems = 250;

    // Machine code of one instruction, first byte at index 0 (the top byte).
    typedef logic [0:MaxBytes-1][7:0] t_code;

    // One row of the directed table. Where typed is set, the bytes are written
    // out by hand; otherwise the in-bench encoder supplies them.
    typedef struct {
        t_req  req;
        bit    typed;
        t_code code;
        int    len;
    } t_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  push;
    logic  full;
    t_req  i_req;
    logic  empty;
    logic  pop;
    t_res  o_res;

    t_res        expected_bytes[$];
    t_row        plan[$];
    logic [31:0] byte_count;
    int          errors;
    int          bytes_seen;
    bit          steady;

    x86_64_instruction_byte_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Most gaps are short, a few are long; none at all while the run is steady.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rex_prefix(input logic [3:0] reg_field,
                                              input logic [3:0] rm_field);
        logic [7:0] rex;
        rex = RexW;
        if (reg_field[3]) begin
            rex = rex | RexR;
        end
        if (rm_field[3]) begin
            rex = rex | RexB;
        end
        return rex;
    endfunction

    function automatic logic [7:0] mod_rm(input logic [7:0] mode,
                                          input logic [3:0] reg_field,
                                          input logic [3:0] rm_field);
        return mode | {2'b00, reg_field[2:0], rm_field[2:0]};
    endfunction

    // Turns one instruction's bytes into results, each carrying the position
    // it holds in the overall byte stream. The position wraps at 32 bits.
    function automatic void queue_bytes(input t_code code, input int len);
        t_res res;
        for (int k = 0; k < len; k++) begin
            res.code_byte     = code[k];
            res.last_byte     = (k == len - 1);
            res.byte_position = byte_count;
            byte_count        = byte_count + 32'd1;
            expected_bytes.push_back(res);
        end
    endfunction

    function automatic void encode_instruction(input t_req r);
        t_code b;
        int    n;
        b = '0;
        n = 0;
        case (r.op)
            OP_STORE, OP_LOAD: begin
                // The register field names the source for a store and the
                // destination for a load; the memory operand is always rbp.
                if (r.op == OP_STORE) begin
                    b[0] = rex_prefix(r.src_reg, 4'd0);
                    b[1] = OpcMovStore;
                    b[2] = mod_rm(ModDisp32, r.src_reg, RegRbp);
                end else begin
                    b[0] = rex_prefix(r.dst_reg, 4'd0);
                    b[1] = OpcMovLoad;
                    b[2] = mod_rm(ModDisp32, r.dst_reg, RegRbp);
                end
                n = 3;
                for (int i = 0; i < 4; i++) begin
                    b[n] = r.displacement[8*i +: 8];
                    n++;
                end
            end
            OP_MOV_IMM: begin
                b[0] = rex_prefix(4'd0, r.dst_reg);
                b[1] = OpcMovImm + {5'd0, r.dst_reg[2:0]};
                n = 2;
                for (int i = 0; i < 8; i++) begin
                    b[n] = r.immediate[8*i +: 8];
                    n++;
                end
            end
            OP_ALU, OP_MOV_RR, OP_CMP: begin
                b[0] = rex_prefix(r.src_reg, r.dst_reg);
                if (r.op == OP_ALU) begin
                    b[1] = r.alu_opcode;
                end else if (r.op == OP_MOV_RR) begin
                    b[1] = OpcMovStore;
                end else begin
                    b[1] = OpcCmp;
                end
                b[2] = mod_rm(ModReg, r.src_reg, r.dst_reg);
                n = 3;
            end
            OP_IMUL, OP_ZERO_EXT: begin
                // Two-byte opcodes with the destination in the reg field.
                b[0] = rex_prefix(r.dst_reg, r.src_reg);
                b[1] = OpcEscape;
                b[2] = (r.op == OP_IMUL) ? OpcImul : OpcMovzx;
                b[3] = mod_rm(ModReg, r.dst_reg, r.src_reg);
                n = 4;
            end
            OP_SETCC: begin
                // From register 4 upwards a bare REX is needed, otherwise
                // 4 to 7 would select the legacy high-byte registers.
                if (r.dst_reg >= 4'd4) begin
                    b[n] = RexBare | (r.dst_reg[3] ? RexB : 8'h00);
                    n++;
                end
                b[n]     = OpcEscape;
                b[n + 1] = OpcSetccBase | {4'h0, r.cond_code};
                b[n + 2] = mod_rm(ModReg, 4'd0, r.dst_reg);
                n        = n + 3;
            end
            default: begin
                n = 0;
            end
        endcase
        queue_bytes(b, n);
    endfunction

    task automatic add_row(input logic [3:0] op, input logic [7:0] alu,
                           input logic [3:0] dst, input logic [3:0] src,
                           input logic [3:0] cc, input logic [31:0] disp,
                           input logic [63:0] imm, input bit typed,
                           input t_code code, input int len);
        t_row row;
        row.req.op           = op;
        row.req.alu_opcode   = alu;
        row.req.dst_reg      = dst;
        row.req.src_reg      = src;
        row.req.cond_code    = cc;
        row.req.displacement = disp;
        row.req.immediate    = imm;
        row.typed            = typed;
        row.code             = code;
        row.len              = len;
        plan.push_back(row);
    endtask

    // Presents one request after a random gap and returns at the clock edge
    // at which it is taken. Push is only ever assigned once per falling edge.
    task automatic send_request(input t_req r);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        do begin
            @(posedge i_clk);
        end while (full);
    endtask

    // Result side: pop is held low for random stretches, set at falling edges.
    initial begin
        int stall;
        stall = 0;
        pop   = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 4) == 0) begin
                    stall = pick_gap();
                end
            end
        end
    end

    // Every byte taken from the block is matched against the oldest one that
    // the bench has queued, from the hand-written table or the encoder model.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (expected_bytes.size() == 0) begin
                report($sformatf("byte %0d: unexpected result %02h", bytes_seen,
                                 o_res.code_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (o_res.code_byte !== want.code_byte) begin
                    report($sformatf("byte %0d: code_byte %02h, expected %02h",
                                     bytes_seen, o_res.code_byte, want.code_byte));
                end
                if (o_res.last_byte !== want.last_byte) begin
                    report($sformatf("byte %0d: last_byte %b, expected %b",
                                     bytes_seen, o_res.last_byte, want.last_byte));
                end
                if (o_res.byte_position !== want.byte_position) begin
                    report($sformatf("byte %0d: byte_position %0d, expected %0d",
                                     bytes_seen, o_res.byte_position,
                                     want.byte_position));
                end
            end
            bytes_seen++;
        end
    end

    initial begin
        t_req req;
        int   sent;

        errors     = 0;
        bytes_seen = 0;
        byte_count = '0;
        steady     = 1'b0;
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_req      = '0;

        // Directed table: extremes of every field, each instruction kind, the
        // byte-register rule of setcc and the unused kinds, which yield nothing.
        add_row(OP_STORE, 8'h00, 4'd0, 4'd0, 4'd0, 32'h0000_0000, 64'd0, 1'b1,
                80'h48_89_85_00_00_00_00_00_00_00, 7);
        add_row(OP_STORE, 8'h00, 4'd0, 4'd15, 4'd0, 32'h7FFF_FFFF, 64'd0, 1'b1,
                80'h4C_89_BD_FF_FF_FF_7F_00_00_00, 7);
        add_row(OP_LOAD, 8'h00, 4'd8, 4'd0, 4'd0, 32'h8000_0000, 64'd0, 1'b1,
                80'h4C_8B_85_00_00_00_80_00_00_00, 7);
        add_row(OP_LOAD, 8'h00, 4'd3, 4'd9, 4'd0, 32'hFFFF_FFFF, 64'd0, 1'b0, '0, 0);
        add_row(OP_MOV_IMM, 8'h00, 4'd0, 4'd0, 4'd0, 32'h0, 64'd0, 1'b1,
                80'h48_B8_00_00_00_00_00_00_00_00, 10);
        add_row(OP_MOV_IMM, 8'h00, 4'd15, 4'd0, 4'd0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                1'b1, 80'h49_BF_FF_FF_FF_FF_FF_FF_FF_FF, 10);
        add_row(OP_MOV_IMM, 8'h00, 4'd9, 4'd4, 4'd0, 32'h0, 64'h0123_4567_89AB_CDEF,
                1'b0, '0, 0);
        add_row(OP_ALU, 8'h01, 4'd0, 4'd0, 4'd0, 32'h0, 64'd0, 1'b1,
                80'h48_01_C0_00_00_00_00_00_00_00, 3);
        add_row(OP_ALU, 8'hFF, 4'd15, 4'd15, 4'd0, 32'h0, 64'd0, 1'b1,
                80'h4D_FF_FF_00_00_00_00_00_00_00, 3);
        add_row(OP_ALU, 8'h29, 4'd10, 4'd3, 4'd0, 32'h0, 64'd0, 1'b0, '0, 0);
        add_row(OP_IMUL, 8'h00, 4'd2, 4'd12, 4'd0, 32'h0, 64'd0, 1'b0, '0, 0);
        add_row(OP_IMUL, 8'h00, 4'd15, 4'd0, 4'd0, 32'h0, 64'd0, 1'b1,
                80'h4C_0F_AF_F8_00_00_00_00_00_00, 4);
        add_row(OP_MOV_RR, 8'h00, 4'd5, 4'd11, 4'd0, 32'h0, 64'd0, 1'b0, '0, 0);
        add_row(OP_CMP, 8'h00, 4'd14, 4'd1, 4'd0, 32'h0, 64'd0, 1'b0, '0, 0);
        add_row(OP_SETCC, 8'h00, 4'd0, 4'd0, 4'd0, 32'h0, 64'd0, 1'b1,
                80'h0F_90_C0_00_00_00_00_00_00_00, 3);
        add_row(OP_SETCC, 8'h00, 4'd3, 4'd0, 4'd4, 32'h0, 64'd0, 1'b0, '0, 0);
        add_row(OP_SETCC, 8'h00, 4'd4, 4'd0, 4'd15, 32'h0, 64'd0, 1'b1,
                80'h40_0F_9F_C4_00_00_00_00_00_00, 4);
        add_row(OP_SETCC, 8'h00, 4'd7, 4'd0, 4'd5, 32'h0, 64'd0, 1'b0, '0, 0);
        add_row(OP_SETCC, 8'h00, 4'd8, 4'd0, 4'd2, 32'h0, 64'd0, 1'b0, '0, 0);
        add_row(OP_SETCC, 8'h00, 4'd15, 4'd15, 4'd15, 32'h0, 64'd0, 1'b1,
                80'h41_0F_9F_C7_00_00_00_00_00_00, 4);
        add_row(OP_ZERO_EXT, 8'h00, 4'd0, 4'd15, 4'd0, 32'h0, 64'd0, 1'b1,
                80'h49_0F_B6_C7_00_00_00_00_00_00, 4);
        add_row(OP_ZERO_EXT, 8'h00, 4'd13, 4'd6, 4'd0, 32'h0, 64'd0, 1'b0, '0, 0);
        add_row(OpUnusedLo, 8'h00, 4'd0, 4'd0, 4'd0, 32'h0, 64'd0, 1'b1, '0, 0);
        add_row(OpUnusedHi, 8'hFF, 4'd15, 4'd15, 4'd15, 32'hFFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0, 0);
        add_row(OP_STORE, 8'h00, 4'd0, 4'd6, 4'd0, 32'h1234_5678, 64'd0, 1'b0, '0, 0);

        // Synchronous reset, released at a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            send_request(plan[i].req);
            if (plan[i].typed) begin
                queue_bytes(plan[i].code, plan[i].len);
            end else begin
                encode_instruction(plan[i].req);
            end
        end

        // Random requests with every field random. A small share carry an
        // unused kind and are not counted; the run alternates between phases
        // with random gaps and phases in which neither side holds back.
        sent = 0;
        while (sent < RandomItems) begin
            if ($urandom_range(0, 39) == 0) begin
                steady = !steady;
            end
            req.alu_opcode = 8'($urandom_range(0, 255));
            req.dst_reg    = 4'($urandom_range(0, 15));
            req.src_reg    = 4'($urandom_range(0, 15));
            req.cond_code  = 4'($urandom_range(0, 15));
            req.immediate  = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0:       req.displacement = 32'h8000_0000;
                1:       req.displacement = 32'h7FFF_FFFF;
                2:       req.displacement = $urandom_range(0, 255);
                default: req.displacement = $urandom;
            endcase
            if ($urandom_range(0, 11) == 0) begin
                req.op = 4'($urandom_range(OpUnusedLo, OpUnusedHi));
            end else begin
                req.op = 4'($urandom_range(OP_STORE, OP_ZERO_EXT));
                sent++;
            end
            send_request(req);
            encode_instruction(req);
        end
        @(negedge i_clk);
        push <= 1'b0;

        // Drain, then give any stray bytes time to show up.
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/x86enc_pkg.sv
hdl/x86enc_front.sv
hdl/x86enc_queue.sv
hdl/x86enc_back.sv
hdl/x86_64_instruction_byte_encoder_top.sv
bench/x86_64_instruction_byte_encoder_top_test.sv
